@@ rtl/hprs_pkg.sv @@
// ----------------------------------------------------------------------------
// hprs_pkg
// Shared constants and controller/datapath command and status types of the
// hazard pointer retire scan unit.
// ----------------------------------------------------------------------------
package hprs_pkg;

	localparam int HAZ_SLOTS = 16;
	localparam int RET_DEPTH = 32;
	localparam int PTR_W     = 48;

	localparam int SLOT_W = 4;
	localparam int THR_W  = 5;
	localparam int ACT_W  = 5;
	localparam int CFG_W  = 5;
	localparam int IDX_W  = $clog2(RET_DEPTH);
	localparam int CNT_W  = $clog2(RET_DEPTH + 1);
	localparam int RAM_AW = IDX_W + 1;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_ACTIVE    = 1'b1;

	localparam logic OP_SET    = 1'b0;
	localparam logic OP_RETIRE = 1'b1;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);
	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

	typedef struct packed {
		logic take;
		logic rd;
		logic keep;
		logic step;
		logic p2_init;
		logic emit_stat;
		logic stat_scanned;
		logic emit_freed;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic is_retire;
		logic scan_need;
		logic idx_zero;
		logic prot;
		logic none_freed;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/hazard_pointer_retire_scan_unit.sv @@
// ----------------------------------------------------------------------------
// hazard_pointer_retire_scan_unit
// Hazard pointer reclamation engine: set-slot and retire requests in, freed
// pointers and retire status out.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------
//   in      | in_valid / in_stall     | operation, slot, pointer
//   out     | out_valid / out_stall   | freed_pointer, freed_valid, scanned,
//           |                         | retained_count, last
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A set-slot request yields no result; a retire without scan yields a status.
// A scan that frees a pointer makes two passes over the buffered pointers,
// each a retire buffer RAM read and then an evaluate step per entry.
// A scan that frees nothing makes one pass, then returns the status.
// Reset empties the hazard table and the retire buffer count; no sweep.
// A stalled result register holds a scan with a result to load until it is taken.
// ----------------------------------------------------------------------------
module hazard_pointer_retire_scan_unit import hprs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PTR_W-1:0]  pointer,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PTR_W-1:0]  freed_pointer,
	output logic              freed_valid,
	output logic              scanned,
	output logic [CNT_W-1:0]  retained_count,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	hprs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hprs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.slot           (slot),
		.pointer        (pointer),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.freed_pointer  (freed_pointer),
		.freed_valid    (freed_valid),
		.scanned        (scanned),
		.retained_count (retained_count),
		.last           (last)
	);

endmodule

@@ rtl/hprs_ram.sv @@
// ----------------------------------------------------------------------------
// hprs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hprs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/hprs_dp.sv @@
// ----------------------------------------------------------------------------
// hprs_dp
// Datapath: hazard table, double-banked retire buffer, scan counters,
// protection compare, configuration registers and result register.
// ----------------------------------------------------------------------------
module hprs_dp import hprs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              operation,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PTR_W-1:0]  pointer,
	input  logic              cfg_wr,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PTR_W-1:0]  freed_pointer,
	output logic              freed_valid,
	output logic              scanned,
	output logic [CNT_W-1:0]  retained_count,
	output logic              last
);

	logic [PTR_W-1:0]  haz_q [HAZ_SLOTS];
	logic [THR_W-1:0]  thr_q;
	logic [ACT_W-1:0]  act_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  kept_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  idx_q;
	logic              bank_q;
	logic              out_valid_q;
	logic [PTR_W-1:0]  out_ptr_q;
	logic              out_fv_q;
	logic              out_sc_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;

	logic [CNT_W-1:0]  count_next;
	logic              has_room;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [PTR_W-1:0]  ram_wdata;
	logic [PTR_W-1:0]  rdata;
	logic              prot;
	logic              load;

	assign has_room   = count_q < CNT_W'(RET_DEPTH);
	assign count_next = has_room ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		prot = 1'b0;
		for (int j = 0; j < HAZ_SLOTS; j++) begin
			if (act_q > ACT_W'(j) && haz_q[j] != '0 && haz_q[j] == rdata) begin
				prot = 1'b1;
			end
		end
	end

	always_comb begin
		if (cmd.keep) begin
			ram_we    = 1'b1;
			ram_waddr = {~bank_q, kept_q[IDX_W-1:0]};
			ram_wdata = rdata;
		end else begin
			ram_we    = cmd.take && operation == OP_RETIRE && has_room;
			ram_waddr = {bank_q, count_q[IDX_W-1:0]};
			ram_wdata = pointer;
		end
	end

	hprs_ram #(
		.WIDTH (PTR_W),
		.DEPTH (2 * RET_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr ({bank_q, idx_q}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HAZ_SLOTS; j++) begin
				haz_q[j] <= '0;
			end
		end else if (cmd.take && operation == OP_SET) begin
			haz_q[slot] <= pointer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			act_q <= ACT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q <= THR_W'(cfg_data);
				CFG_ACTIVE:    act_q <= ACT_W'(cfg_data);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kept_q  <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			priority if (cmd.take && operation == OP_RETIRE) begin
				count_q <= count_next;
				idx_q   <= IDX_W'(count_next - CNT_W'(1));
				kept_q  <= '0;
			end else if (cmd.p2_init) begin
				idx_q <= IDX_W'(count_q - CNT_W'(1));
				rem_q <= count_q - kept_q;
			end else if (cmd.finish) begin
				bank_q  <= ~bank_q;
				count_q <= kept_q;
			end else begin
				if (cmd.keep) begin
					kept_q <= kept_q + CNT_W'(1);
				end
				if (cmd.step) begin
					idx_q <= idx_q - IDX_W'(1);
				end
				if (cmd.emit_freed) begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end
		end
	end

	assign load = cmd.emit_stat || cmd.emit_freed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_freed) begin
			out_ptr_q  <= rdata;
			out_fv_q   <= 1'b1;
			out_sc_q   <= 1'b1;
			out_cnt_q  <= kept_q;
			out_last_q <= rem_q == CNT_W'(1);
		end else if (cmd.emit_stat) begin
			out_ptr_q  <= '0;
			out_fv_q   <= 1'b0;
			out_sc_q   <= cmd.stat_scanned;
			out_cnt_q  <= cmd.stat_scanned ? kept_q : count_q;
			out_last_q <= 1'b1;
		end
	end

	assign sts.is_retire  = operation == OP_RETIRE;
	assign sts.scan_need  = count_next > CNT_W'(thr_q) || count_next >= CNT_W'(RET_DEPTH);
	assign sts.idx_zero   = idx_q == '0;
	assign sts.prot       = prot;
	assign sts.none_freed = kept_q == count_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign freed_pointer  = out_ptr_q;
	assign freed_valid    = out_fv_q;
	assign scanned        = out_sc_q;
	assign retained_count = out_cnt_q;
	assign last           = out_last_q;

endmodule

@@ rtl/hprs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hprs_ctrl
// Controller: takes requests and sequences the two scan passes over the
// retire buffer, one entry per read state and evaluate state pair.
// ----------------------------------------------------------------------------
module hprs_ctrl import hprs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_STAT  = 3'd1;
	localparam logic [2:0] ST_RD1   = 3'd2;
	localparam logic [2:0] ST_EV1   = 3'd3;
	localparam logic [2:0] ST_END1  = 3'd4;
	localparam logic [2:0] ST_STATS = 3'd5;
	localparam logic [2:0] ST_RD2   = 3'd6;
	localparam logic [2:0] ST_EV2   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.is_retire) begin
						state_d = sts.scan_need ? ST_RD1 : ST_STAT;
					end
				end
			end
			ST_STAT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RD1: begin
				cmd.rd  = 1'b1;
				state_d = ST_EV1;
			end
			ST_EV1: begin
				cmd.keep = sts.prot;
				if (sts.idx_zero) begin
					state_d = ST_END1;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_RD1;
				end
			end
			ST_END1: begin
				if (sts.none_freed) begin
					state_d = ST_STATS;
				end else begin
					cmd.p2_init = 1'b1;
					state_d     = ST_RD2;
				end
			end
			ST_STATS: begin
				if (sts.out_free) begin
					cmd.emit_stat    = 1'b1;
					cmd.stat_scanned = 1'b1;
					cmd.finish       = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_RD2: begin
				cmd.rd  = 1'b1;
				state_d = ST_EV2;
			end
			ST_EV2: begin
				if (sts.prot || sts.out_free) begin
					cmd.emit_freed = !sts.prot;
					if (sts.idx_zero) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_RD2;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/hprs_chk.sv @@
// ----------------------------------------------------------------------------
// hprs_chk
// Port-level checker for the hazard pointer retire scan unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module hprs_chk import hprs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PTR_W-1:0] freed_pointer,
	input logic             freed_valid,
	input logic             scanned,
	input logic [CNT_W-1:0] retained_count,
	input logic             last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(freed_pointer) && $stable(last))
		else $error("result changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !freed_valid |-> last && freed_pointer == '0)
		else $error("status result not final or carries a pointer");

	a_plain_retire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !scanned |-> !freed_valid && retained_count != '0)
		else $error("unscanned retire reported a free or an empty buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> retained_count <= CNT_W'(RET_DEPTH))
		else $error("retained count beyond buffer depth");

endmodule

bind hazard_pointer_retire_scan_unit hprs_chk u_hprs_chk (.*);

@@ tb/sv/hazard_pointer_retire_scan_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hazard_pointer_retire_scan_unit_tb
// Self-checking bench for the hazard pointer retire scan unit. A short table
// of directed requests and register writes leads into random phases. Each
// phase sets the threshold, the active slot count or both, then sends
// set-slot and retire requests. Some phases flood the retire buffer with one
// protected pointer past full. A behavioural model predicts the results that
// directed rows do not fix; each accepted result is compared field by field.
// ----------------------------------------------------------------------------
module hazard_pointer_retire_scan_unit_tb;
	import hprs_pkg::*;

	localparam int RANDOM_TARGET = 340;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [PTR_W-1:0] freed_pointer;
		logic             freed_valid;
		logic             scanned;
		logic [CNT_W-1:0] retained_count;
		logic             last;
	} reclaim_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              sel;
		logic [SLOT_W-1:0] slot;
		logic [PTR_W-1:0]  value;
		logic              typed;
		logic              exp_scanned;
		logic [CNT_W-1:0]  exp_count;
	} plan_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              operation = OP_SET;
	logic [SLOT_W-1:0] slot      = '0;
	logic [PTR_W-1:0]  pointer   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PTR_W-1:0]  freed_pointer;
	logic              freed_valid;
	logic              scanned;
	logic [CNT_W-1:0]  retained_count;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_THRESHOLD;
	logic [CFG_W-1:0]  cfg_data  = '0;

	hazard_pointer_retire_scan_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.slot          (slot),
		.pointer       (pointer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.freed_pointer (freed_pointer),
		.freed_valid   (freed_valid),
		.scanned       (scanned),
		.retained_count(retained_count),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// model state
	logic [PTR_W-1:0] haz_slots [HAZ_SLOTS];
	logic [PTR_W-1:0] retired [RET_DEPTH];
	int unsigned      retired_cnt;
	logic [THR_W-1:0] thr_reg;
	logic [ACT_W-1:0] act_reg;

	reclaim_result_t  step_out [$];
	reclaim_result_t  awaited_results [$];
	logic [PTR_W-1:0] ptr_pool [8];

	int unsigned idle_pct      = 22;
	int unsigned requests_sent = 0;
	int unsigned full_drops    = 0;
	int unsigned results_seen  = 0;
	int unsigned scans_seen    = 0;
	int unsigned freed_seen    = 0;
	int unsigned fault_count   = 0;
	int unsigned cycle_count   = 0;

	plan_row_t directed_plan [$] = '{
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'h0000_0000_0000, 1'b1, 1'b0, 6'd1},
		'{ROW_ITEM, OP_RETIRE,     4'd9,  48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 6'd2},
		'{ROW_ITEM, OP_SET,        4'd0,  48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_SET,        4'd15, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 6'd3},
		'{ROW_ITEM, OP_RETIRE,     4'd15, 48'h5555_5555_5555, 1'b1, 1'b0, 6'd4},
		'{ROW_CFG,  CFG_THRESHOLD, 4'd0,  48'd0,              1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd3,  48'h1234_5678_9ABC, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG,  CFG_ACTIVE,    4'd0,  48'd0,              1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd6,  48'h0000_0000_0007, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG,  CFG_ACTIVE,    4'd0,  48'd1,              1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 6'd1},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG,  CFG_ACTIVE,    4'd0,  48'd31,             1'b0, 1'b0, 6'd0},
		'{ROW_CFG,  CFG_THRESHOLD, 4'd0,  48'd31,             1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 6'd2},
		'{ROW_ITEM, OP_SET,        4'd0,  48'h0000_0000_0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_SET,        4'd7,  48'h8000_0000_0000, 1'b0, 1'b0, 6'd0},
		'{ROW_CFG,  CFG_THRESHOLD, 4'd0,  48'd2,              1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'h8000_0000_0000, 1'b0, 1'b0, 6'd0},
		'{ROW_ITEM, OP_RETIRE,     4'd0,  48'h0000_0000_0001, 1'b0, 1'b0, 6'd0}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("hazard_pointer_retire_scan_unit_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [PTR_W-1:0] wide_pointer();
		return PTR_W'({$urandom, $urandom});
	endfunction

	function automatic logic [CFG_W-1:0] pick_threshold();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom_range(20));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_active();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return CFG_W'(HAZ_SLOTS);
			3: return CFG_W'($urandom_range(31, HAZ_SLOTS + 1));
			default: return CFG_W'($urandom_range(HAZ_SLOTS, 1));
		endcase
	endfunction

	function automatic bit is_guarded(input logic [PTR_W-1:0] p, input int unsigned act);
		for (int i = 0; i < act; i++)
			if (haz_slots[i] != '0 && haz_slots[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void predict_reclaim(input logic op, input logic [SLOT_W-1:0] s,
			input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] snap [RET_DEPTH];
		logic [PTR_W-1:0] freed_q [$];
		int unsigned      act;
		int unsigned      kept;
		reclaim_result_t  r;
		step_out.delete();
		if (op == OP_SET) begin
			haz_slots[s] = p;
			return;
		end
		// drop the pointer when the buffer is already full
		if (retired_cnt < RET_DEPTH) begin
			retired[retired_cnt] = p;
			retired_cnt++;
		end else begin
			full_drops++;
		end
		r = '0;
		r.last = 1'b1;
		if (retired_cnt <= thr_reg && retired_cnt < RET_DEPTH) begin
			r.retained_count = CNT_W'(retired_cnt);
			step_out.push_back(r);
			return;
		end
		act = (act_reg > HAZ_SLOTS) ? HAZ_SLOTS : act_reg;
		snap = retired;
		kept = 0;
		// walk newest first; restack kept pointers in walk order
		for (int i = int'(retired_cnt) - 1; i >= 0; i--) begin
			if (is_guarded(snap[i], act)) begin
				retired[kept] = snap[i];
				kept++;
			end else begin
				freed_q.push_back(snap[i]);
			end
		end
		retired_cnt = kept;
		r.scanned = 1'b1;
		r.retained_count = CNT_W'(kept);
		if (freed_q.size() == 0) begin
			step_out.push_back(r);
			return;
		end
		r.freed_valid = 1'b1;
		foreach (freed_q[k]) begin
			r.freed_pointer = freed_q[k];
			r.last = (k == freed_q.size() - 1);
			step_out.push_back(r);
		end
	endfunction

	task automatic send_request(input logic op, input logic [SLOT_W-1:0] s,
			input logic [PTR_W-1:0] p, input bit use_typed, input reclaim_result_t typed_res);
		cfg_valid <= 1'b0;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		in_valid  <= 1'b1;
		operation <= op;
		slot      <= s;
		pointer   <= p;
		do @(posedge clk); while (in_stall);
		predict_reclaim(op, s, p);
		requests_sent++;
		if (use_typed)
			awaited_results.push_back(typed_res);
		else
			foreach (step_out[k])
				awaited_results.push_back(step_out[k]);
	endtask

	task automatic write_register(input logic idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_THRESHOLD)
			thr_reg = THR_W'(val);
		else
			act_reg = ACT_W'(val);
	endtask

	// hold the sender until every expected result has come and the scan is over
	task automatic settle_idle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (awaited_results.size() != 0 || in_stall) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		reclaim_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (scanned && last)
				scans_seen++;
			if (freed_valid)
				freed_seen++;
			if (awaited_results.size() == 0) begin
				$error("unexpected result: freed_pointer %h freed_valid %b",
					freed_pointer, freed_valid);
				fault_count++;
			end else begin
				want = awaited_results.pop_front();
				if (freed_pointer !== want.freed_pointer) begin
					$error("freed_pointer: expected %h, got %h", want.freed_pointer,
						freed_pointer);
					fault_count++;
				end
				if (freed_valid !== want.freed_valid) begin
					$error("freed_valid: expected %b, got %b", want.freed_valid, freed_valid);
					fault_count++;
				end
				if (scanned !== want.scanned) begin
					$error("scanned: expected %b, got %b", want.scanned, scanned);
					fault_count++;
				end
				if (retained_count !== want.retained_count) begin
					$error("retained_count: expected %0d, got %0d", want.retained_count,
						retained_count);
					fault_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					fault_count++;
				end
			end
		end
		out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
	end

	initial begin
		plan_row_t         row;
		reclaim_result_t   fixed;
		logic              op;
		logic [PTR_W-1:0]  p;
		logic [PTR_W-1:0]  anchor;
		int unsigned       random_start;
		int unsigned       phase;
		foreach (haz_slots[i])
			haz_slots[i] = '0;
		foreach (retired[i])
			retired[i] = '0;
		retired_cnt = 0;
		thr_reg = THR_RESET;
		act_reg = ACT_RESET;
		foreach (ptr_pool[i])
			ptr_pool[i] = wide_pointer();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_CFG) begin
				settle_idle();
				write_register(row.sel, row.value[CFG_W-1:0]);
			end else begin
				fixed = '0;
				fixed.scanned = row.exp_scanned;
				fixed.retained_count = row.exp_count;
				fixed.last = 1'b1;
				send_request(row.sel, row.slot, row.value, row.typed, fixed);
			end
		end

		random_start = requests_sent;
		phase = 0;
		while (requests_sent - random_start < RANDOM_TARGET) begin
			settle_idle();
			idle_pct = (phase >= 3 && phase < 7) ? 0 : 22;
			if (phase == 1 || $urandom_range(5) == 0) begin
				// fill the buffer with one protected pointer, overflow it, then release
				write_register(CFG_ACTIVE, CFG_W'($urandom_range(HAZ_SLOTS, 1)));
				write_register(CFG_THRESHOLD, pick_threshold());
				anchor = wide_pointer() | PTR_W'(1);
				send_request(OP_SET, '0, anchor, 1'b0, '0);
				repeat ($urandom_range(RET_DEPTH + 6, RET_DEPTH + 3))
					send_request(OP_RETIRE, SLOT_W'($urandom), anchor, 1'b0, '0);
				send_request(OP_RETIRE, SLOT_W'($urandom), wide_pointer(), 1'b0, '0);
				send_request(OP_SET, '0, '0, 1'b0, '0);
				send_request(OP_RETIRE, SLOT_W'($urandom), ptr_pool[$urandom_range(7)],
					1'b0, '0);
			end else begin
				case ($urandom_range(3))
					0: begin
						write_register(CFG_THRESHOLD, pick_threshold());
						write_register(CFG_ACTIVE, pick_active());
					end
					1: begin
						write_register(CFG_ACTIVE, pick_active());
						write_register(CFG_THRESHOLD, pick_threshold());
					end
					2: write_register(CFG_THRESHOLD, pick_threshold());
					default: write_register(CFG_ACTIVE, pick_active());
				endcase
				repeat ($urandom_range(40, 12)) begin
					if ($urandom_range(99) < 25) begin
						op = OP_SET;
						case ($urandom_range(9))
							0, 1, 2: p = '0;
							3, 4, 5, 6, 7: p = ptr_pool[$urandom_range(7)];
							default: p = wide_pointer();
						endcase
					end else begin
						op = OP_RETIRE;
						case ($urandom_range(9))
							0, 1, 2, 3: p = haz_slots[$urandom_range(HAZ_SLOTS - 1)];
							4, 5, 6: p = ptr_pool[$urandom_range(7)];
							7: p = '0;
							default: p = wide_pointer();
						endcase
					end
					send_request(op, SLOT_W'($urandom), p, 1'b0, '0);
				end
			end
			phase++;
		end

		settle_idle();
		$display("covered %0d requests over %0d random phases, %0d retires dropped on a full buffer",
			requests_sent, phase, full_drops);
		$display("checked %0d results: %0d scans, %0d pointers freed",
			results_seen, scans_seen, freed_seen);
		if (fault_count == 0)
			$display("hazard_pointer_retire_scan_unit_tb: done, clean");
		else
			$display("hazard_pointer_retire_scan_unit_tb: done, errors");
		$finish;
	end

endmodule
